// ----- rtl/core/icwt_pkg.sv -----
package icwt_pkg;

  localparam int DEFAULT_SLOT_COUNT = 16;

  localparam int BYTE_W = 32;
  localparam int REQ_W = 16;
  localparam int GLOBAL_W = 36;
  localparam int SLOT_W = 4;
  localparam int OPCODE_W = 3;
  localparam int ENTRY_W = REQ_W + BYTE_W;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_CONN_BYTE_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_BYTE_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONN_REQUEST_LIMIT = 2'd2;

  localparam logic [BYTE_W-1:0] CONN_BYTE_LIMIT_RESET = 32'd65536;
  localparam logic [BYTE_W-1:0] TOTAL_BYTE_LIMIT_RESET = 32'd0;
  localparam logic [REQ_W-1:0] CONN_REQUEST_LIMIT_RESET = 16'd64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_RESERVE       = 3'd0,
    OP_RELEASE_BYTES = 3'd1,
    OP_ACCOUNT       = 3'd2,
    OP_COUNT_ONLY    = 3'd3,
    OP_RELEASE_REQ   = 3'd4,
    OP_CHECK_PAUSE   = 3'd5,
    OP_CLOSE         = 3'd6,
    OP_OPEN          = 3'd7
  } opcode_t;

  function automatic int addr_width(input int depth);
    addr_width = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- rtl/core/icwt_ram.sv -----
module icwt_ram #(
  parameter int WIDTH = icwt_pkg::ENTRY_W,
  parameter int DEPTH = icwt_pkg::DEFAULT_SLOT_COUNT
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [icwt_pkg::addr_width(DEPTH)-1:0]    waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [icwt_pkg::addr_width(DEPTH)-1:0]    raddr,
  output logic [WIDTH-1:0]                          rdata
);
  import icwt_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/inflight_credit_watermark_tracker.sv -----
// In-flight credit tracker with high and low watermark flow control. A command is
// taken when start is high and busy is low. Every command produces at least one
// result, shown for exactly one cycle with result_strobe high; the receiver cannot
// stall, so each result must be captured in the cycle it appears. A command to a
// slot outside the configured slot count is answered straight from idle. Count-only,
// check-pause, close, open, a zero-byte reserve and a zero-byte release of bytes end
// after the execute step; any other reserve and account add the global step; any other
// release adds the global step and a resume scan, of the released slot alone when the
// global limit is 0 and of the first min(SLOT_COUNT, 16) slots otherwise. The steps
// follow from the single read port of the per-slot counter memory, which the resume
// scan visits one slot at a time, and the one adder, used for slot then global counter.
module inflight_credit_watermark_tracker #(
  parameter int SLOT_COUNT = icwt_pkg::DEFAULT_SLOT_COUNT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [icwt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [icwt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic [icwt_pkg::OPCODE_W-1:0]     opcode,
  input  logic [icwt_pkg::SLOT_W-1:0]       slot,
  input  logic [icwt_pkg::BYTE_W-1:0]       byte_count,
  output logic                              result_strobe,
  output logic                              outcome,
  output logic                              resumed_valid,
  output logic [icwt_pkg::SLOT_W-1:0]       resumed_slot,
  output logic                              last
);
  import icwt_pkg::*;

  localparam int AW = addr_width(SLOT_COUNT);
  localparam int SCAN_N = (SLOT_COUNT < 16) ? SLOT_COUNT : 16;
  localparam logic [AW-1:0] SCAN_LAST = AW'(SCAN_N - 1);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_EXEC     = 6'b000010,
    ST_GLOB     = 6'b000100,
    ST_SCAN_RD  = 6'b001000,
    ST_SCAN_CHK = 6'b010000,
    ST_SCAN_FIN = 6'b100000
  } state_t;

  state_t state;

  logic [BYTE_W-1:0]   conn_byte_limit;
  logic [BYTE_W-1:0]   total_byte_limit;
  logic [REQ_W-1:0]    conn_request_limit;

  logic [GLOBAL_W-1:0] inflight_total;
  logic [SLOT_COUNT-1:0] slot_paused;
  logic [SLOT_COUNT-1:0] slot_closing;
  logic [SLOT_COUNT-1:0] slot_open;
  logic [SLOT_COUNT-1:0] entry_valid;

  opcode_t             op_q;
  logic [AW-1:0]       slot_q;
  logic [BYTE_W-1:0]   count_q;
  logic [BYTE_W-1:0]   tmp_bytes;
  logic [REQ_W-1:0]    tmp_req;
  logic                slot_ok;

  logic [AW-1:0]       scan_idx;
  logic [AW-1:0]       scan_end;
  logic                pend_valid;
  logic [AW-1:0]       pend_slot;

  logic                in_range;
  logic                accept;
  logic [AW-1:0]       ram_raddr;
  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                rd_valid;

  logic [BYTE_W-1:0]   cur_bytes;
  logic [REQ_W-1:0]    cur_req;
  logic [REQ_W-1:0]    req_inc;
  logic [REQ_W-1:0]    req_dec;

  logic [GLOBAL_W-1:0] unit_a;
  logic                unit_sub;
  logic [GLOBAL_W:0]   unit_sum;
  logic [GLOBAL_W-1:0] unit_sat;

  logic                reserve_ok;
  logic                global_ok;
  logic                above;
  logic                resume;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;
  assign in_range = (int'(slot) < SLOT_COUNT);

  assign cur_bytes = rd_valid ? ram_rdata[BYTE_W-1:0] : '0;
  assign cur_req = rd_valid ? ram_rdata[ENTRY_W-1:BYTE_W] : '0;
  assign req_inc = cur_req + REQ_W'(1);
  assign req_dec = (cur_req == '0) ? '0 : cur_req - REQ_W'(1);

  // The shared adder works on the slot byte counter in the execute step and
  // on the global byte counter in the step after it.
  always_comb begin
    unit_a = (state == ST_GLOB) ? inflight_total : GLOBAL_W'(cur_bytes);
    unit_sub = (op_q == OP_RELEASE_BYTES) || (op_q == OP_RELEASE_REQ);
    if (unit_sub) begin
      unit_sum = {1'b0, unit_a} - (GLOBAL_W + 1)'(count_q);
    end else begin
      unit_sum = {1'b0, unit_a} + (GLOBAL_W + 1)'(count_q);
    end
    unit_sat = unit_sum[GLOBAL_W] ? '0 : unit_sum[GLOBAL_W-1:0];
  end

  assign reserve_ok = slot_ok && (unit_sum <= (GLOBAL_W + 1)'(total_byte_limit));

  assign above = ((total_byte_limit != '0) && (inflight_total >= GLOBAL_W'(total_byte_limit)))
                 || (cur_req >= conn_request_limit) || (cur_bytes >= conn_byte_limit);

  assign global_ok = (total_byte_limit == '0)
                     || (inflight_total <= GLOBAL_W'(total_byte_limit[BYTE_W-1:1]));

  assign resume = slot_paused[scan_idx] && slot_open[scan_idx] && !slot_closing[scan_idx]
                  && global_ok && (cur_req <= {1'b0, conn_request_limit[REQ_W-1:1]})
                  && (cur_bytes <= {1'b0, conn_byte_limit[BYTE_W-1:1]});

  assign ram_raddr = (state == ST_IDLE) ? AW'(slot) : scan_idx;

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = {cur_req, cur_bytes};
    if (state == ST_EXEC) begin
      unique case (op_q)
        OP_ACCOUNT: begin
          ram_we = 1'b1;
          ram_wdata = {req_inc, unit_sum[BYTE_W-1:0]};
        end
        OP_COUNT_ONLY: begin
          ram_we = 1'b1;
          ram_wdata = {req_inc, cur_bytes};
        end
        OP_RELEASE_BYTES: begin
          ram_we = (count_q != '0);
          ram_wdata = {cur_req, unit_sat[BYTE_W-1:0]};
        end
        OP_RELEASE_REQ: begin
          ram_we = 1'b1;
          ram_wdata = {req_dec, unit_sat[BYTE_W-1:0]};
        end
        default: begin
        end
      endcase
    end else if ((state == ST_GLOB) && (op_q == OP_RESERVE)) begin
      ram_we = reserve_ok;
      ram_wdata = {tmp_req, tmp_bytes};
    end
  end

  icwt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_counters (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_q),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      conn_byte_limit <= CONN_BYTE_LIMIT_RESET;
      total_byte_limit <= TOTAL_BYTE_LIMIT_RESET;
      conn_request_limit <= CONN_REQUEST_LIMIT_RESET;
      inflight_total <= '0;
      slot_paused <= '0;
      slot_closing <= '0;
      slot_open <= '0;
      entry_valid <= '0;
      rd_valid <= 1'b0;
      pend_valid <= 1'b0;
      result_strobe <= 1'b0;
      outcome <= 1'b0;
      resumed_valid <= 1'b0;
      resumed_slot <= '0;
      last <= 1'b0;
    end else begin
      result_strobe <= 1'b0;

      if (cfg_write) begin
        unique case (cfg_index)
          CFG_CONN_BYTE_LIMIT: conn_byte_limit <= cfg_data;
          CFG_TOTAL_BYTE_LIMIT: total_byte_limit <= cfg_data;
          CFG_CONN_REQUEST_LIMIT: conn_request_limit <= cfg_data[REQ_W-1:0];
          default: begin
          end
        endcase
      end

      if (state == ST_IDLE) begin
        rd_valid <= in_range ? entry_valid[AW'(slot)] : 1'b0;
      end else begin
        rd_valid <= entry_valid[ram_raddr];
      end

      if (ram_we) begin
        entry_valid[slot_q] <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_q <= opcode_t'(opcode);
            slot_q <= AW'(slot);
            count_q <= byte_count;
            if (in_range) begin
              state <= ST_EXEC;
            end else begin
              result_strobe <= 1'b1;
              outcome <= 1'b0;
              resumed_valid <= 1'b0;
              resumed_slot <= '0;
              last <= 1'b1;
            end
          end
        end

        ST_EXEC: begin
          outcome <= 1'b0;
          resumed_valid <= 1'b0;
          resumed_slot <= '0;
          last <= 1'b1;
          unique case (op_q)
            OP_RESERVE: begin
              if (count_q == '0) begin
                result_strobe <= 1'b1;
                outcome <= 1'b1;
                state <= ST_IDLE;
              end else begin
                tmp_bytes <= unit_sum[BYTE_W-1:0];
                tmp_req <= cur_req;
                slot_ok <= (unit_sum[BYTE_W:0] <= {1'b0, conn_byte_limit});
                state <= ST_GLOB;
              end
            end
            OP_RELEASE_BYTES: begin
              if (count_q == '0) begin
                result_strobe <= 1'b1;
                state <= ST_IDLE;
              end else begin
                state <= ST_GLOB;
              end
            end
            OP_ACCOUNT, OP_RELEASE_REQ: begin
              state <= ST_GLOB;
            end
            OP_COUNT_ONLY: begin
              result_strobe <= 1'b1;
              state <= ST_IDLE;
            end
            OP_CHECK_PAUSE: begin
              if (above && slot_open[slot_q]) begin
                slot_paused[slot_q] <= 1'b1;
                outcome <= 1'b1;
              end
              result_strobe <= 1'b1;
              state <= ST_IDLE;
            end
            OP_CLOSE: begin
              slot_closing[slot_q] <= 1'b1;
              result_strobe <= 1'b1;
              state <= ST_IDLE;
            end
            OP_OPEN: begin
              slot_open[slot_q] <= 1'b1;
              slot_closing[slot_q] <= 1'b0;
              slot_paused[slot_q] <= 1'b0;
              result_strobe <= 1'b1;
              state <= ST_IDLE;
            end
          endcase
        end

        ST_GLOB: begin
          outcome <= 1'b0;
          resumed_valid <= 1'b0;
          resumed_slot <= '0;
          last <= 1'b1;
          priority if (op_q == OP_RESERVE) begin
            if (reserve_ok) begin
              inflight_total <= unit_sum[GLOBAL_W-1:0];
              outcome <= 1'b1;
            end
            result_strobe <= 1'b1;
            state <= ST_IDLE;
          end else if (op_q == OP_ACCOUNT) begin
            inflight_total <= unit_sum[GLOBAL_W-1:0];
            result_strobe <= 1'b1;
            state <= ST_IDLE;
          end else begin
            inflight_total <= unit_sat;
            pend_valid <= 1'b0;
            if (total_byte_limit == '0) begin
              scan_idx <= slot_q;
              scan_end <= slot_q;
            end else begin
              scan_idx <= '0;
              scan_end <= SCAN_LAST;
            end
            state <= ST_SCAN_RD;
          end
        end

        ST_SCAN_RD: begin
          state <= ST_SCAN_CHK;
        end

        // A resumed slot is held back so that the final one can carry last.
        ST_SCAN_CHK: begin
          if (resume) begin
            slot_paused[scan_idx] <= 1'b0;
            pend_valid <= 1'b1;
            pend_slot <= scan_idx;
            if (pend_valid) begin
              result_strobe <= 1'b1;
              outcome <= 1'b0;
              resumed_valid <= 1'b1;
              resumed_slot <= SLOT_W'(pend_slot);
              last <= 1'b0;
            end
          end
          if (scan_idx == scan_end) begin
            state <= ST_SCAN_FIN;
          end else begin
            scan_idx <= scan_idx + AW'(1);
            state <= ST_SCAN_RD;
          end
        end

        ST_SCAN_FIN: begin
          result_strobe <= 1'b1;
          outcome <= 1'b0;
          resumed_valid <= pend_valid;
          resumed_slot <= pend_valid ? SLOT_W'(pend_slot) : '0;
          last <= 1'b1;
          state <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
